@@ rtl/core/line_bounded_pattern_matcher_macros.svh @@
// Assertion macros shared by the pattern matcher modules.
`ifndef LINE_BOUNDED_PATTERN_MATCHER_MACROS_SVH
`define LINE_BOUNDED_PATTERN_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

`define LBPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lbpm assertion failed");

`define LBPM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lbpm reset assertion failed");

`else

`define LBPM_ASSERT(lbl, prop)

`define LBPM_ASSERT_RST(lbl, prop)

`endif

`endif

@@ rtl/core/lbpm_pkg.sv @@
// Shared types, constants and helpers of the line-bounded pattern matcher.
package lbpm_pkg;

  localparam logic [7:0]  NewlineByte = 8'd10;
  localparam logic [31:0] CntMax      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    RegPatLow  = 2'd0,
    RegPatHigh = 2'd1,
    RegPatLen  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] line_number;
    logic [31:0] match_in_text;
    logic [31:0] match_total;
  } lbpm_result_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == CntMax) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/core/lbpm_cell.sv @@
// One window cell: holds one text byte and compares its incoming byte with its pattern byte.
module lbpm_cell #(
  parameter int MAX_PATTERN = 16,
  parameter int IDX         = 0
) (
  input  logic                                  clk_i,
  input  logic                                  shift_i,
  input  logic [7:0]                            byte_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]      eff_len_i,
  input  logic [MAX_PATTERN-1:0][7:0]           pattern_i,
  output logic [7:0]                            byte_o,
  output logic                                  eq_o
);
  import lbpm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]    win_q;
  logic          active;
  logic [LW-1:0] sel;
  logic [7:0]    pat_byte;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= byte_i;
    end
  end

  assign active   = eff_len_i > LW'(IDX);
  assign sel      = eff_len_i - LW'(IDX) - LW'(1);
  assign pat_byte = pattern_i[sel[IW-1:0]];
  assign eq_o     = !active || (byte_i == pat_byte);
  assign byte_o   = win_q;

endmodule

@@ rtl/core/lbpm_out_buf.sv @@
// Two-entry result buffer: output register with a skid stage behind it.
module lbpm_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lbpm_pkg::lbpm_result_t data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  stall_i,
  output lbpm_pkg::lbpm_result_t data_o
);
  import lbpm_pkg::*;
  `include "line_bounded_pattern_matcher_macros.svh"

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  lbpm_result_t out_q, out_d;
  lbpm_result_t skid_q, skid_d;
  logic         pop;

  assign pop = out_valid_q && !stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  `LBPM_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q)
  `LBPM_ASSERT(a_no_push_when_full, skid_valid_q |-> !push_i)
  `LBPM_ASSERT_RST(a_empty_in_reset, !rst_ni |=> !out_valid_q && !skid_valid_q)

endmodule

@@ rtl/core/line_bounded_pattern_matcher.sv @@
// Top level of the line-bounded pattern matcher: register port, cell chain, counters.
//
//   channel   direction  handshake                      payload
//   in        request    in_valid_i / in_stall_o         text_byte_i, new_text_i
//   out       request    out_valid_o / out_stall_i       line_number_o, match_in_text_o,
//                                                        match_total_o
//   config    APB write  psel, penable, pwrite, pready   paddr, pwdata (prdata on read)
//
// One text byte is taken each cycle while in_stall_o is low; the window compare and
// counter update finish in that same cycle; a match is registered in the output buffer.
// in_stall_o rises only while both the output register and the skid stage hold requests.
// Reset empties the window and clears all counters; pattern_length resets to one.
module line_bounded_pattern_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        new_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] line_number_o,
  output logic [31:0] match_in_text_o,
  output logic [31:0] match_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import lbpm_pkg::*;
  `include "line_bounded_pattern_matcher_macros.svh"

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [63:0]   pat_lo_q, pat_hi_q;
  logic [4:0]    plen_q;
  cfg_reg_e      reg_sel;
  logic          cfg_wr;

  logic [MAX_PATTERN-1:0][7:0] pattern;
  logic [MAX_PATTERN:0][7:0]   chain;
  logic [MAX_PATTERN-1:0]      eq;
  logic [LW-1:0]               eff_len;
  logic [7:0]                  len8;

  logic [LW-1:0] vc_q, vc_d, vc_base, vc_lim, vc_inc;
  logic [31:0]   nl_q, nl_d, nl_base;
  logic [31:0]   tm_q, tm_d, tm_base;
  logic [31:0]   tot_q, tot_d;
  logic          in_acc, is_nl, hit, shift, push, buf_full;
  lbpm_result_t  res, out_res;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= 5'd1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegPatLow:  pat_lo_q <= pwdata;
        RegPatHigh: pat_hi_q <= pwdata;
        RegPatLen:  plen_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegPatLow:  prdata = pat_lo_q;
      RegPatHigh: prdata = pat_hi_q;
      RegPatLen:  prdata = {59'd0, plen_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    len8 = {3'd0, plen_q};
    if (len8 == 8'd0) begin
      eff_len = LW'(1);
    end else if (len8 > 8'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = len8[LW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < 8) begin : g_lo
      assign pattern[k] = pat_lo_q[8*k +: 8];
    end else if (k < 16) begin : g_hi
      assign pattern[k] = pat_hi_q[8*(k-8) +: 8];
    end else begin : g_zero
      assign pattern[k] = 8'd0;
    end
  end

  assign chain[0] = text_byte_i;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    lbpm_cell #(
      .MAX_PATTERN(MAX_PATTERN),
      .IDX        (j)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .byte_i   (chain[j]),
      .eff_len_i(eff_len),
      .pattern_i(pattern),
      .byte_o   (chain[j+1]),
      .eq_o     (eq[j])
    );
  end

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_nl      = text_byte_i == NewlineByte;
  assign shift      = in_acc && !is_nl;

  always_comb begin
    nl_base = new_text_i ? 32'd0 : nl_q;
    tm_base = new_text_i ? 32'd0 : tm_q;
    vc_base = new_text_i ? LW'(0) : vc_q;
    vc_lim  = (vc_base > eff_len) ? eff_len : vc_base;
    vc_inc  = (vc_lim < eff_len) ? vc_lim + LW'(1) : vc_lim;
    hit     = !is_nl && (vc_inc == eff_len) && (&eq);

    res.line_number   = sat_inc(nl_base);
    res.match_in_text = sat_inc(tm_base);
    res.match_total   = sat_inc(tot_q);

    nl_d  = nl_q;
    tm_d  = tm_q;
    tot_d = tot_q;
    vc_d  = vc_q;
    if (in_acc) begin
      nl_d  = is_nl ? sat_inc(nl_base) : nl_base;
      tm_d  = hit ? res.match_in_text : tm_base;
      tot_d = hit ? res.match_total : tot_q;
      vc_d  = (is_nl || hit) ? LW'(0) : vc_inc;
    end
  end

  assign push = in_acc && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= '0;
      nl_q  <= '0;
      tm_q  <= '0;
      tot_q <= '0;
    end else begin
      vc_q  <= vc_d;
      nl_q  <= nl_d;
      tm_q  <= tm_d;
      tot_q <= tot_d;
    end
  end

  lbpm_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .full_o (buf_full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_res)
  );

  assign line_number_o   = out_res.line_number;
  assign match_in_text_o = out_res.match_in_text;
  assign match_total_o   = out_res.match_total;

  `LBPM_ASSERT(a_vc_bounded, vc_q <= LW'(MAX_PATTERN))
  `LBPM_ASSERT(a_newline_clears, in_acc && is_nl |=> vc_q == LW'(0))
  `LBPM_ASSERT(a_total_monotonic, 1'b1 |=> tot_q >= $past(tot_q))
  `LBPM_ASSERT(a_text_le_total, tm_q <= tot_q)

endmodule
